/* src/ucbs_pkg.sv */
// Shared types and constants for the uniform cubic B-spline evaluator.
// Holds field widths, stream packing offsets, fixed-point constants and the
// write-port struct. No dependencies.
package ucbs_pkg;

  // Field widths
  localparam int IDX_W   = 5;
  localparam int COEF_W  = 32;
  localparam int X_W     = 18;
  localparam int Y_W     = 32;
  localparam int SEG_W   = 5;

  // Stream packing (tdata fields from the lowest bit up)
  localparam int IDX_LSB   = 0;
  localparam int COEF_LSB  = IDX_LSB + IDX_W;
  localparam int X_LSB     = COEF_LSB + COEF_W;
  localparam int Y_LSB     = X_LSB + X_W;
  localparam int S_FIELD_W = Y_LSB + Y_W;
  localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = COEF_W;

  // Fixed-point layout
  localparam int FRAC_T  = 17;                 // t and u fraction bits
  localparam int TQ_W    = X_W + SEG_W;
  localparam int U_W     = FRAC_T + 1;         // u in (0,1]
  localparam int V_W     = FRAC_T;             // v = 1 - u in [0,1)
  localparam int SLOT_W  = 8;                  // signed slot, -1 .. 64
  localparam int U2_W    = 2 * FRAC_T + 1;
  localparam int U3_W    = 3 * FRAC_T + 1;
  localparam int NUM_W   = 3 * FRAC_T + 4;     // basis numerators, times 6
  localparam int W_FRAC  = 30;                 // weight fraction bits
  localparam int H_LSB   = 3 * FRAC_T - W_FRAC + 1;
  localparam int H_W     = 32;
  localparam int W_W     = 30;
  localparam int PROD_W  = COEF_W + W_W + 1;
  localparam int ACC_W   = 64;

  localparam int NUM_LANES = 4;
  localparam int BANK_W    = 2;

  // floor(h / 3) = (h * DIV3_MAGIC) >> DIV3_SHIFT for any 32-bit h
  localparam logic [H_W-1:0] DIV3_MAGIC = 32'hAAAA_AAAB;
  localparam int             DIV3_SHIFT = 33;

  localparam logic [U_W-1:0]   ONE_U    = U_W'(1) << FRAC_T;
  localparam logic [NUM_W-1:0] NUM_BIAS = NUM_W'(3) << (H_LSB - 1);
  localparam logic [NUM_W-1:0] NUM_TOP  = (NUM_W'(1) << (3 * FRAC_T + 2)) + NUM_BIAS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (W_FRAC - 1);

  localparam logic [COEF_W-1:0] RES_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] RES_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic {
    OP_EVAL = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  slot;
    logic [COEF_W-1:0] data;
  } ucbs_wr_t;

endpackage

/* src/ucbs_coef_store.sv */
// Coefficient store: four banks interleaved on slot[1:0], so any four
// consecutive slots are read together in the same cycle, one per bank.
// Depends on ucbs_pkg.
module ucbs_coef_store
  import ucbs_pkg::*;
#(
  parameter int MAX_COEFS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ucbs_wr_t                            wr,
  input  logic                                rd_en,
  input  logic [NUM_LANES-1:0][SLOT_W-1:0]    rd_slot,   // slot per bank
  output logic [NUM_LANES-1:0][COEF_W-1:0]    rd_data    // zero if never written
);

  localparam int ROWS  = (MAX_COEFS + NUM_LANES - 1) / NUM_LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [ROW_W-1:0]  wr_row;
  logic [BANK_W-1:0] wr_bank;

  assign wr_row  = ROW_W'(wr.slot[IDX_W-1:BANK_W]);
  assign wr_bank = wr.slot[BANK_W-1:0];

  for (genvar b = 0; b < NUM_LANES; b++) begin : g_bank
    logic [COEF_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   written;
    logic [COEF_W-1:0] rdat;
    logic              rhit;
    logic [ROW_W-1:0]  rrow;
    logic              wsel;

    assign rrow = ROW_W'(rd_slot[b][SLOT_W-1:BANK_W]);
    assign wsel = wr.en && (wr_bank == BANK_W'(b));

    always_ff @(posedge clk) begin
      if (wsel) begin
        mem[wr_row] <= wr.data;
      end
      if (rd_en) begin
        rdat <= mem[rrow];
        rhit <= written[rrow];
      end
    end

    // Reset marks every entry unwritten
    always_ff @(posedge clk) begin
      if (rst) begin
        written <= '0;
      end else if (wsel) begin
        written[wr_row] <= 1'b1;
      end
    end

    assign rd_data[b] = rhit ? rdat : '0;
  end

endmodule

/* src/uniform_cubic_bspline_eval_core.sv */
// Top level of the uniform cubic B-spline residual evaluator.
// Depends on ucbs_pkg and ucbs_coef_store.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | tuser: operation; tdata: coef_index, coef_value,
//           |     |                    |   sample_x, target_y
//   m_      | out | m_tvalid/m_tready  | tuser: saturated; tdata: residual
//   cfg_    | in  | cfg_we             | cfg_wdata: segment_count
//
// One item per cycle sustained while the output is not stalled; an evaluate result
// passes the store read, the u^2 / u^3 multiplies, the divide-by-3 multiply, the
// coefficient multiply and the two-level sum. Load items write the store at accept
// and give no result. Reset clears the entry-written flags; no sweep.
// Stalls back up stage by stage; empty stages are squeezed out, so s_tready stays
// high while the output register waits if any stage is free.
module uniform_cubic_bspline_eval_core
  import ucbs_pkg::*;
#(
  parameter int MAX_COEFS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // coef_index, coef_value, sample_x, target_y
  input  logic [0:0]            s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // residual
  output logic [0:0]            m_tuser,   // saturated
  input  logic                  cfg_we,
  input  logic [SEG_W-1:0]      cfg_wdata
);

  localparam int NSTG  = 7;
  localparam int CMP_W = $clog2(MAX_COEFS + 128);

  logic [SEG_W-1:0] seg_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= SEG_W'(1);
    end else if (cfg_we) begin
      seg_count <= cfg_wdata;
    end
  end

  // ---------------- input fields
  op_t                      in_op;
  logic [IDX_W-1:0]         in_idx;
  logic [COEF_W-1:0]        in_coef;
  logic [X_W-1:0]           in_x;
  logic signed [Y_W-1:0]    in_y;
  logic                     in_acc;

  assign in_op   = op_t'(s_tuser[0]);
  assign in_idx  = s_tdata[IDX_LSB +: IDX_W];
  assign in_coef = s_tdata[COEF_LSB +: COEF_W];
  assign in_x    = s_tdata[X_LSB +: X_W];
  assign in_y    = s_tdata[Y_LSB +: Y_W];
  assign in_acc  = s_tvalid && s_tready;

  // ---------------- stall chain
  logic [NSTG:1] vld;
  logic [NSTG:1] ld;
  logic          ld_out;

  always_comb begin
    ld_out   = !m_tvalid || m_tready;
    ld[NSTG] = !vld[NSTG] || ld_out;
    for (int k = NSTG - 1; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign s_tready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ld[1]) begin
        vld[1] <= in_acc && (in_op == OP_EVAL);
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (ld_out) begin
        m_tvalid <= vld[NSTG];
      end
    end
  end

  // ---------------- stage 0: segment, position, slots
  logic [TQ_W-1:0]                   tq;
  logic [TQ_W-1:0]                   tq_m1;
  logic                              tq_zero;
  logic [SLOT_W-1:0]                 j0;
  logic [U_W-1:0]                    u0;
  logic [V_W-1:0]                    v0;
  logic [CMP_W-1:0]                  lim;
  logic [NUM_LANES-1:0]              inr0;
  logic [NUM_LANES-1:0][SLOT_W-1:0]  bank_slot;

  always_comb begin
    logic [SLOT_W-1:0] slot;
    logic [BANK_W-1:0] kb;
    tq      = TQ_W'(in_x) * TQ_W'(seg_count);
    tq_m1   = tq - TQ_W'(1);
    tq_zero = (tq == '0);
    // t = 0 sits in segment -1 at u = 1
    j0  = tq_zero ? '1 : SLOT_W'(tq_m1[TQ_W-1:FRAC_T]);
    u0  = tq_zero ? ONE_U : U_W'(tq_m1[FRAC_T-1:0]) + U_W'(1);
    v0  = V_W'(ONE_U - u0);
    lim = CMP_W'(seg_count) + CMP_W'(3);
    for (int k = 0; k < NUM_LANES; k++) begin
      slot    = j0 + SLOT_W'(k);
      inr0[k] = !slot[SLOT_W-1] && (CMP_W'(slot) < lim)
                && (CMP_W'(slot) < CMP_W'(MAX_COEFS));
    end
    // bank b holds the lane whose slot is congruent to b mod 4
    for (int b = 0; b < NUM_LANES; b++) begin
      kb           = BANK_W'(b) - j0[BANK_W-1:0];
      bank_slot[b] = j0 + SLOT_W'(kb);
    end
  end

  ucbs_wr_t                         st_wr;
  logic [NUM_LANES-1:0][COEF_W-1:0] st_rd;

  // Reads and writes both issue at the accept edge in item order, so a load
  // never overlaps the read of an earlier evaluate.
  always_comb begin
    st_wr.en   = in_acc && (in_op == OP_LOAD) && (CMP_W'(in_idx) < CMP_W'(MAX_COEFS));
    st_wr.slot = in_idx;
    st_wr.data = in_coef;
  end

  ucbs_coef_store #(
    .MAX_COEFS (MAX_COEFS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (st_wr),
    .rd_en   (ld[1]),
    .rd_slot (bank_slot),
    .rd_data (st_rd)
  );

  // ---------------- stage 1
  logic [BANK_W-1:0]     p1_jlo;
  logic [NUM_LANES-1:0]  p1_inr;
  logic [U_W-1:0]        p1_u;
  logic [V_W-1:0]        p1_v;
  logic signed [Y_W-1:0] p1_y;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p1_jlo <= j0[BANK_W-1:0];
      p1_inr <= inr0;
      p1_u   <= u0;
      p1_v   <= v0;
      p1_y   <= in_y;
    end
  end

  logic signed [COEF_W-1:0] p1_coef [NUM_LANES];
  logic [2*U_W-1:0]         sq_u;
  logic [2*V_W-1:0]         sq_v;
  logic signed [ACC_W-1:0]  y_ext;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      p1_coef[k] = p1_inr[k] ? st_rd[BANK_W'(p1_jlo + BANK_W'(k))] : '0;
    end
    sq_u  = p1_u * p1_u;
    sq_v  = p1_v * p1_v;
    y_ext = ACC_W'(p1_y);
  end

  // ---------------- stage 2
  logic [U_W-1:0]           p2_u;
  logic [V_W-1:0]           p2_v;
  logic [U2_W-1:0]          p2_u2;
  logic [U2_W-1:0]          p2_v2;
  logic signed [COEF_W-1:0] p2_coef [NUM_LANES];
  logic signed [ACC_W-1:0]  p2_ty;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      p2_u    <= p1_u;
      p2_v    <= p1_v;
      p2_u2   <= U2_W'(sq_u);
      p2_v2   <= U2_W'(sq_v);
      p2_coef <= p1_coef;
      p2_ty   <= ROUND_HALF - (y_ext <<< W_FRAC);
    end
  end

  logic [U2_W+U_W-1:0] cu_u;
  logic [U2_W+V_W-1:0] cu_v;

  assign cu_u = p2_u2 * p2_u;
  assign cu_v = p2_v2 * p2_v;

  // ---------------- stage 3
  logic [U3_W-1:0]          p3_u3;
  logic [U3_W-1:0]          p3_v3;
  logic [U2_W-1:0]          p3_u2;
  logic [U2_W-1:0]          p3_v2;
  logic signed [COEF_W-1:0] p3_coef [NUM_LANES];
  logic signed [ACC_W-1:0]  p3_ty;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      p3_u3   <= U3_W'(cu_u);
      p3_v3   <= U3_W'(cu_v);
      p3_u2   <= p2_u2;
      p3_v2   <= p2_v2;
      p3_coef <= p2_coef;
      p3_ty   <= p2_ty;
    end
  end

  // Numerators times 6, with the rounding bias folded in. The middle two
  // basis functions mirror each other under u <-> 1 - u.
  logic [NUM_W-1:0] num [NUM_LANES];

  always_comb begin
    num[0] = NUM_W'(p3_v3) + NUM_BIAS;
    num[3] = NUM_W'(p3_u3) + NUM_BIAS;
    num[1] = (NUM_W'(p3_u3) << 1) + NUM_W'(p3_u3) + NUM_TOP
             - (NUM_W'(p3_u2) << (FRAC_T + 2)) - (NUM_W'(p3_u2) << (FRAC_T + 1));
    num[2] = (NUM_W'(p3_v3) << 1) + NUM_W'(p3_v3) + NUM_TOP
             - (NUM_W'(p3_v2) << (FRAC_T + 2)) - (NUM_W'(p3_v2) << (FRAC_T + 1));
  end

  // ---------------- stage 4
  logic [H_W-1:0]           p4_h [NUM_LANES];
  logic signed [COEF_W-1:0] p4_coef [NUM_LANES];
  logic signed [ACC_W-1:0]  p4_ty;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        p4_h[k] <= num[k][H_LSB +: H_W];
      end
      p4_coef <= p3_coef;
      p4_ty   <= p3_ty;
    end
  end

  logic [2*H_W-1:0] div3 [NUM_LANES];

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      div3[k] = p4_h[k] * DIV3_MAGIC;
    end
  end

  // ---------------- stage 5
  logic [W_W-1:0]           p5_w [NUM_LANES];
  logic signed [COEF_W-1:0] p5_coef [NUM_LANES];
  logic signed [ACC_W-1:0]  p5_ty;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        p5_w[k] <= div3[k][DIV3_SHIFT +: W_W];
      end
      p5_coef <= p4_coef;
      p5_ty   <= p4_ty;
    end
  end

  logic signed [PROD_W-1:0] prod [NUM_LANES];

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      prod[k] = p5_coef[k] * $signed({1'b0, p5_w[k]});
    end
  end

  // ---------------- stage 6
  logic signed [PROD_W-1:0] p6_prod [NUM_LANES];
  logic signed [ACC_W-1:0]  p6_ty;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      p6_prod <= prod;
      p6_ty   <= p5_ty;
    end
  end

  // ---------------- stage 7
  logic signed [ACC_W-1:0] p7_s01;
  logic signed [ACC_W-1:0] p7_s23;
  logic signed [ACC_W-1:0] p7_ty;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      p7_s01 <= ACC_W'(p6_prod[0]) + ACC_W'(p6_prod[1]);
      p7_s23 <= ACC_W'(p6_prod[2]) + ACC_W'(p6_prod[3]);
      p7_ty  <= p6_ty;
    end
  end

  // ---------------- final sum, round, saturate
  logic signed [ACC_W-1:0] acc;
  logic                    ovf;
  logic [COEF_W-1:0]       res;
  logic [2:0]              top_bits;

  always_comb begin
    acc      = p7_s01 + p7_s23 + p7_ty;
    top_bits = acc[ACC_W-1 -: 3];
    // result fits when the bits above the 32-bit field all match its sign
    ovf      = !((top_bits == 3'b000) || (top_bits == 3'b111));
    if (ovf) begin
      res = acc[ACC_W-1] ? RES_MIN : RES_MAX;
    end else begin
      res = acc[W_FRAC +: COEF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      m_tdata    <= res;
      m_tuser[0] <= ovf;
    end
  end

endmodule

/* src/ucbs_checker.sv */
// Port-level checks for the B-spline evaluator, bound to the top level.
// Depends on ucbs_pkg and uniform_cubic_bspline_eval_core.
module ucbs_checker
  import ucbs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [0:0]           m_tuser
);

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A clipped result carries one of the two limit codes
  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> ((m_tdata == RES_MAX) || (m_tdata == RES_MIN)))
    else $error("saturated flag with non-limit residual");

  // A free or draining output register lets every stage move, so s_tready is high
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input held back while output can drain");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind uniform_cubic_bspline_eval_core ucbs_checker u_ucbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
